/* rtl/gri_pkg.sv */
// shared widths, register indexes and angle limits for the gyro rate integrator
// no dependencies; imported by the top level and its checker
package gri_pkg;

  localparam int unsigned NumAxes   = 3;
  localparam int unsigned AxisW     = 2;
  localparam int unsigned ReadingW  = 16;
  localparam int unsigned RateW     = 32;
  localparam int unsigned AngleW    = 25;
  localparam int unsigned MaskW     = 3;
  localparam int unsigned SensW     = 16;
  localparam int unsigned DeadbandW = 24;
  localparam int unsigned StepW     = 18;
  localparam int unsigned ProdW     = RateW + StepW + 1;
  localparam int unsigned IncW      = ProdW - 24;
  localparam int unsigned AccW      = IncW + 1;

  localparam int unsigned InDataW   = 2 * NumAxes * 8;
  localparam int unsigned OutFieldW = NumAxes * (RateW + AngleW);
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = DeadbandW;

  // register indexes of the configuration channel
  localparam logic [CfgIndexW-1:0] RegSensitivity = 2'd0;
  localparam logic [CfgIndexW-1:0] RegDeadband    = 2'd1;
  localparam logic [CfgIndexW-1:0] RegTimeStep    = 2'd2;

  localparam logic [SensW-1:0]     SensReset     = 16'd4588;
  localparam logic [DeadbandW-1:0] DeadbandReset = 24'd262144;
  localparam logic [StepW-1:0]     StepReset     = 18'd167772;

  // Q16.16 angle limits
  localparam logic signed [AccW-1:0] DEG180 = AccW'(180 * 65536);
  localparam logic signed [AccW-1:0] DEG360 = AccW'(360 * 65536);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1 << 23);

  // control word carried along the axis pipeline
  typedef struct packed {
    logic             vld;
    logic [AxisW-1:0] axis;
    logic             flag;
  } gri_stage_t;

endpackage

/* rtl/gri_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module gri_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gyro_rate_deadband_integrator_unit.sv */
// gyro rate integrator with deadband: top level, sequencer and axis datapath
// depends on gri_pkg and gri_ram
//
// flow: an accepted sample set passes the issue, drain and done states into the output
//   register; a new set is taken only in idle; the three axes stream through a three-stage
//   read / multiply / write-back loop around the angle ram, one axis per cycle
// reset: angles read as zero (valid bits cleared), registers take their reset values,
//   no result pending; a sample set with an empty mask is taken and dropped
module gyro_rate_deadband_integrator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample sets
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
  input  logic [gri_pkg::InDataW-1:0]   s_axis_tdata,
  // new_data_mask
  input  logic [gri_pkg::MaskW-1:0]     s_axis_tuser,
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // rate_x, rate_y, rate_z, angle_x, angle_y, angle_z, zero fill
  output logic [gri_pkg::OutDataW-1:0]  m_axis_tdata,
  // updated_mask
  output logic [gri_pkg::MaskW-1:0]     m_axis_tuser,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gri_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [gri_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gri_pkg::*;

  // sequencer states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [AxisW-1:0] issue_cnt_q, issue_cnt_d;

  // configuration registers
  logic [SensW-1:0]     sens_q;
  logic [DeadbandW-1:0] deadband_q;
  logic [StepW-1:0]     step_q;

  // the accepted sample set
  logic [InDataW-1:0] item_data_q;
  logic [MaskW-1:0]   item_mask_q;

  // angle store bookkeeping: an entry never written reads as zero
  logic [NumAxes-1:0] ang_vld_q;

  // pipeline control and payload
  gri_stage_t                s1_q, s2_q;
  logic signed [RateW-1:0]   s1_rate_q;
  logic signed [ProdW-1:0]   s2_prod_q;
  logic signed [RateW-1:0]   s2_rate_q;
  logic signed [AngleW-1:0]  s2_angle_q;

  // result being assembled, then the output register
  logic signed [RateW-1:0]  res_rate_q  [NumAxes];
  logic signed [AngleW-1:0] res_angle_q [NumAxes];
  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q;
  logic [MaskW-1:0]         out_user_q;

  logic in_xfer, out_free, issue;
  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign issue         = (state_q == StIssue);
  assign cfg_ready_o   = 1'b1;

  // sequencer
  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    case (state_q)
      StIdle: begin
        // an empty mask causes no work and no result
        if (in_xfer && (s_axis_tuser != '0)) begin
          state_d     = StIssue;
          issue_cnt_d = '0;
        end
      end
      StIssue: begin
        issue_cnt_d = issue_cnt_q + AxisW'(1);
        if (issue_cnt_q == AxisW'(NumAxes - 1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (s2_q.vld && (s2_q.axis == AxisW'(NumAxes - 1))) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      issue_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q     <= SensReset;
      deadband_q <= DeadbandReset;
      step_q     <= StepReset;
    end else if (cfg_valid_i) begin
      // indexes beyond the register list are ignored
      case (cfg_index_i)
        RegSensitivity: sens_q     <= cfg_data_i[SensW-1:0];
        RegDeadband:    deadband_q <= cfg_data_i;
        RegTimeStep:    step_q     <= cfg_data_i[StepW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_data_q <= s_axis_tdata;
      item_mask_q <= s_axis_tuser;
    end
  end

  // stage 0: read the axis angle, scale the raw reading by the sensitivity
  logic signed [ReadingW-1:0] reading;
  logic signed [RateW:0]      rate_full;
  assign reading   = signed'(item_data_q[{issue_cnt_q, 4'b0000} +: ReadingW]);
  assign rate_full = reading * signed'({1'b0, sens_q});

  // stage 2 outputs used by the ram write port
  logic                    wb_we;
  logic signed [AngleW-1:0] wb_angle;
  logic signed [AngleW-1:0] ram_rdata;

  gri_ram #(
    .Width (AngleW),
    .Depth (NumAxes)
  ) u_angle_ram (
    .clk_i   (clk_i),
    .we_i    (wb_we),
    .waddr_i (s2_q.axis),
    .wdata_i (wb_angle),
    .re_i    (issue),
    .raddr_i (issue_cnt_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q.vld  <= issue;
      s1_q.axis <= issue_cnt_q;
      s1_q.flag <= item_mask_q[issue_cnt_q];
      s2_q      <= s1_q;
    end
  end

  // stage 1: deadband, then rate times time step
  logic signed [RateW:0]    rate_ext, db_ext;
  logic                     in_band;
  logic signed [RateW-1:0]  rate_db;
  logic signed [AngleW-1:0] angle_rd;
  assign rate_ext = {s1_rate_q[RateW-1], s1_rate_q};
  assign db_ext   = signed'({{(RateW + 1 - DeadbandW){1'b0}}, deadband_q});
  assign in_band  = (rate_ext > -db_ext) && (rate_ext < db_ext);
  assign rate_db  = (s1_q.flag && !in_band) ? s1_rate_q : '0;
  assign angle_rd = ang_vld_q[s1_q.axis] ? ram_rdata : '0;

  always_ff @(posedge clk_i) begin
    s1_rate_q  <= rate_full[RateW-1:0];
    s2_prod_q  <= rate_db * signed'({1'b0, step_q});
    s2_rate_q  <= rate_db;
    s2_angle_q <= angle_rd;
  end

  // stage 2: round the increment, accumulate, wrap once, clamp
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [IncW-1:0]  inc;
  logic signed [AccW-1:0]  acc, acc_lo, acc_hi, acc_sat;
  always_comb begin
    prod_rnd = s2_prod_q + RoundHalf;
    inc      = prod_rnd[ProdW-1:24];
    acc      = AccW'(s2_angle_q) + AccW'(inc);
    acc_lo   = (acc < -DEG180) ? acc + DEG360 : acc;
    acc_hi   = (acc_lo > DEG180) ? acc_lo - DEG360 : acc_lo;
    // only an increment of more than 360 degrees leaves the angle outside after one correction
    if (acc_hi > DEG180) begin
      acc_sat = DEG180;
    end else if (acc_hi < -DEG180) begin
      acc_sat = -DEG180;
    end else begin
      acc_sat = acc_hi;
    end
  end

  assign wb_angle = acc_sat[AngleW-1:0];
  assign wb_we    = s2_q.vld & s2_q.flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_vld_q <= '0;
    end else if (wb_we) begin
      ang_vld_q[s2_q.axis] <= 1'b1;
    end
  end

  // unflagged axes pass their stored angle through with a zero rate
  always_ff @(posedge clk_i) begin
    if (s2_q.vld) begin
      res_rate_q[s2_q.axis]  <= s2_rate_q;
      res_angle_q[s2_q.axis] <= wb_angle;
    end
  end

  // output register: a finished result waits here while the next set is worked on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      out_data_q <= OutDataW'({res_angle_q[2], res_angle_q[1], res_angle_q[0],
                               res_rate_q[2], res_rate_q[1], res_rate_q[0]});
      out_user_q <= item_mask_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

/* rtl/gri_checker.sv */
// port-level checks for the gyro rate integrator, bound to the top level
// depends on gri_pkg
module gri_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [gri_pkg::MaskW-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gri_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [gri_pkg::MaskW-1:0]     m_axis_tuser
);
  import gri_pkg::*;

  logic signed [AccW-1:0] ang_x, ang_y, ang_z;
  assign ang_x = AccW'(signed'(m_axis_tdata[3*RateW +: AngleW]));
  assign ang_y = AccW'(signed'(m_axis_tdata[3*RateW + AngleW +: AngleW]));
  assign ang_z = AccW'(signed'(m_axis_tdata[3*RateW + 2*AngleW +: AngleW]));

  // a set with work on it keeps the slave side closed in the next cycle
  busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != '0)) |=> !s_axis_tready)
    else $error("slave side open while a sample set is in work");

  // results are given only for sets with at least one flagged axis
  mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != '0))
    else $error("result with empty mask");

  // every shown angle stays in [-180, 180]
  angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ang_x >= -DEG180) && (ang_x <= DEG180) &&
                      (ang_y >= -DEG180) && (ang_y <= DEG180) &&
                      (ang_z >= -DEG180) && (ang_z <= DEG180))
    else $error("angle out of range");

  // a stalled result holds
  out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind gyro_rate_deadband_integrator_unit gri_checker u_gri_checker (.*);
